/* src/asv_pkg.sv */
// asv_pkg: shared codes, constants and elaboration-time tables for the sine voice.
// No dependencies; imported by the voice core and its port checker.
`default_nettype none

package asv_pkg;

  // Default build parameters
  localparam int unsigned DEF_SAMPLE_RATE    = 48000;
  localparam int unsigned DEF_SINE_ADDR_BITS = 10;
  localparam int unsigned DEF_PHASE_BITS     = 32;

  // Input word action codes
  localparam logic [1:0] ACT_TICK     = 2'd0;
  localparam logic [1:0] ACT_NOTE_ON  = 2'd1;
  localparam logic [1:0] ACT_SOFT_OFF = 2'd2;
  localparam logic [1:0] ACT_HARD_OFF = 2'd3;

  // Envelope stage codes
  localparam logic [2:0] ENV_IDLE    = 3'd0;
  localparam logic [2:0] ENV_ATTACK  = 3'd1;
  localparam logic [2:0] ENV_DECAY   = 3'd2;
  localparam logic [2:0] ENV_SUSTAIN = 3'd3;
  localparam logic [2:0] ENV_RELEASE = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF   = 3'd4;

  // Register reset values
  localparam logic [23:0] RST_ATTACK  = 24'd17476;
  localparam logic [23:0] RST_DECAY   = 24'd349;
  localparam logic [23:0] RST_SUSTAIN = 24'd14260633;
  localparam logic [23:0] RST_RELEASE = 24'd540;
  localparam logic [15:0] RST_COEFF   = 16'd22938;

  localparam logic [23:0] ENV_ONE = 24'hFFFFFF;

  // Shared multiplier operand width (signed)
  localparam int unsigned MUL_W = 25;

  // Quarter-wave polynomial coefficients, Q15
  localparam logic [15:0] SINE_C0 = 16'd51459;
  localparam logic [15:0] SINE_C1 = 16'd21060;
  localparam logic [15:0] SINE_C2 = 16'd2369;

  // Partial weights: 0.7, 0.7*0.18, 0.7*0.08 in Q16
  localparam logic [15:0] MIX_W1 = 16'd45875;
  localparam logic [15:0] MIX_W2 = 16'd8258;
  localparam logic [15:0] MIX_W3 = 16'd3670;

  // Lowest-octave note frequencies, units of 1e-7 Hz
  localparam longint unsigned LOW_OCT_FREQ [12] = '{
    64'd81757989,  64'd86619572,  64'd91770240,  64'd97227182,
    64'd103008612, 64'd109133822, 64'd115623257, 64'd122498574,
    64'd129782718, 64'd137500000, 64'd145676175, 64'd154338532
  };

  // Phase step for a note: round(f * 2^pbits / rate), low 32 bits kept.
  function automatic logic [31:0] note_step(int unsigned note, int unsigned rate,
                                            int unsigned pbits);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] rem;
    logic [127:0] quo;
    int unsigned  idx;
    int unsigned  oct;
    idx = note;
    oct = 0;
    while (idx >= 12) begin
      idx = idx - 12;
      oct = oct + 1;
    end
    num = 128'(LOW_OCT_FREQ[idx]) << oct;
    num = num << (pbits + 1);
    den = 128'(64'd10000000 * 64'(rate));
    rem = '0;
    quo = '0;
    for (int i = 127; i >= 0; i--) begin
      rem = {rem[126:0], num[i]};
      quo = quo << 1;
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
    end
    quo = (quo + 128'd1) >> 1;
    return quo[31:0];
  endfunction

  // Voice level from velocity, Q0.16: 0.22 * max(vel/127, 0.05)
  localparam int unsigned LEVEL_W = 14;
  typedef logic [LEVEL_W-1:0] level_tab_t [128];

  function automatic level_tab_t build_level_tab();
    level_tab_t t;
    for (int v = 0; v < 128; v++) begin
      if (v < 7) t[v] = LEVEL_W'(721);
      else       t[v] = LEVEL_W'((v * 1135269 + 5000) / 10000);
    end
    return t;
  endfunction

  localparam level_tab_t LEVEL_TAB = build_level_tab();

endpackage

`default_nettype wire

/* src/additive_sine_voice_core.sv */
// additive_sine_voice_core: one additive sine voice with low-pass filter and ADSR envelope.
// Depends on asv_pkg for codes, constants and the velocity level table.
`default_nettype none

// One synthesizer voice. Input words carry an action (tick, note on, soft note off,
// hard note off) with note and velocity; each tick word yields one result word with
// a signed Q1.15 sample, a sounding flag and an ended flag. Note-on and note-off
// words finish in the cycle they are accepted and give no result. A tick on a
// sounding voice keeps the input stalled until its result word is loaded, so no
// new word is taken before the tick is done: three partials each take five passes
// through the one shared 25x25 signed multiplier (x*x, two polynomial terms, the
// sine value, the partial weight), then mix, filter multiply, filter update,
// envelope multiply, rounding, level multiply and output take seven more steps.
// A tick while the voice is idle goes straight to the output step. The last step
// waits while the previous result word is still stalled at the output register.
// Configuration writes are taken at any cycle and are meant for idle periods only.
module additive_sine_voice_core
  import asv_pkg::*;
#(
  parameter int unsigned SAMPLE_RATE    = DEF_SAMPLE_RATE,
  parameter int unsigned SINE_ADDR_BITS = DEF_SINE_ADDR_BITS,
  parameter int unsigned PHASE_BITS     = DEF_PHASE_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            action_i,
  input  wire logic [6:0]            note_i,
  input  wire logic [6:0]            velocity_i,
  // output channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic signed [15:0]         sample_o,
  output logic                       sounding_o,
  output logic                       ended_o
);

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SX   = 4'd1;   // x*x
  localparam logic [3:0] S_SP   = 4'd2;   // x2*C2 -> p
  localparam logic [3:0] S_SQ   = 4'd3;   // x2*p  -> q
  localparam logic [3:0] S_SY   = 4'd4;   // x*q   -> sine value
  localparam logic [3:0] S_SW   = 4'd5;   // y*weight, accumulate
  localparam logic [3:0] S_MIX  = 4'd6;   // round mix, filter difference, envelope step
  localparam logic [3:0] S_FM   = 4'd7;   // diff*coeff
  localparam logic [3:0] S_FU   = 4'd8;   // filter update with clamp
  localparam logic [3:0] S_EM   = 4'd9;   // filter*envelope
  localparam logic [3:0] S_ER   = 4'd10;  // round by 2^24
  localparam logic [3:0] S_LM   = 4'd11;  // value*level
  localparam logic [3:0] S_OUT  = 4'd12;  // round, saturate, load output word

  localparam int unsigned X_SHIFT = 17 - SINE_ADDR_BITS;

  // Phase step per note, built at elaboration for this sample rate and phase width
  typedef logic [PHASE_BITS-1:0] step_tab_t [128];

  function automatic step_tab_t build_step_tab();
    step_tab_t   t;
    logic [31:0] s;
    for (int n = 0; n < 128; n++) begin
      s    = note_step(n, SAMPLE_RATE, PHASE_BITS);
      t[n] = s[PHASE_BITS-1:0];
    end
    return t;
  endfunction

  localparam step_tab_t STEP_TAB = build_step_tab();

  // Configuration registers
  logic [23:0] attack_q, attack_d;
  logic [23:0] decay_q, decay_d;
  logic [23:0] sustain_q, sustain_d;
  logic [23:0] release_q, release_d;
  logic [15:0] coeff_q, coeff_d;

  // Voice state
  logic [PHASE_BITS-1:0] phase_acc_q, phase_acc_d;
  logic [PHASE_BITS-1:0] phase_step_q, phase_step_d;
  logic [LEVEL_W-1:0]    level_q, level_d;
  logic signed [23:0]    filt_q, filt_d;
  logic [23:0]           env_q, env_d;
  logic [2:0]            stage_q, stage_d;

  // Sequencer and working registers
  logic [3:0]         state_q, state_d;
  logic [1:0]         part_q, part_d;
  logic               silent_q, silent_d;
  logic               fin_q, fin_d;
  logic [15:0]        x2_q, x2_d;
  logic [15:0]        t_q, t_d;
  logic signed [15:0] y_q, y_d;
  logic signed [31:0] acc_q, acc_d;
  logic signed [24:0] diff_q, diff_d;
  logic signed [47:0] prod_q, prod_d;

  // Output word register
  logic               out_valid_q, out_valid_d;
  logic signed [15:0] sample_q, sample_d;
  logic               sounding_q, sounding_d;
  logic               ended_q, ended_d;

  // Shared multiplier
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;

  // Combinational helpers
  logic [PHASE_BITS-1:0]     part_phase;
  logic [SINE_ADDR_BITS-1:0] sine_addr;
  logic [1:0]                quad;
  logic [15:0]               x_raw, x_val;
  logic [15:0]               y_mag;
  logic signed [33:0]        mix_sum;
  logic signed [26:0]        fu_sum;
  logic signed [47:0]        prod_rnd;
  logic signed [23:0]        out_val;
  logic signed [25:0]        env_nxt;

  assign mul_p = mul_a * mul_b;

  // Partial index k reads the top address bits of (k+1)*phase, modulo the phase width
  always_comb begin
    case (part_q)
      2'd0:    part_phase = phase_acc_q;
      2'd1:    part_phase = phase_acc_q << 1;
      default: part_phase = phase_acc_q + (phase_acc_q << 1);
    endcase
    sine_addr = part_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
    quad      = sine_addr[SINE_ADDR_BITS-1 -: 2];
    x_raw     = 16'(sine_addr[SINE_ADDR_BITS-3:0]) << X_SHIFT;
    // mirror odd quadrants
    x_val     = quad[0] ? (16'd32768 - x_raw) : x_raw;
  end

  // Rounding by 2^24 shared by the envelope and level scaling steps
  assign prod_rnd = (prod_q + 48'sd8388608) >>> 24;
  assign out_val  = 24'(prod_rnd);

  always_comb begin
    attack_d     = attack_q;
    decay_d      = decay_q;
    sustain_d    = sustain_q;
    release_d    = release_q;
    coeff_d      = coeff_q;
    phase_acc_d  = phase_acc_q;
    phase_step_d = phase_step_q;
    level_d      = level_q;
    filt_d       = filt_q;
    env_d        = env_q;
    stage_d      = stage_q;
    state_d      = state_q;
    part_d       = part_q;
    silent_d     = silent_q;
    fin_d        = fin_q;
    x2_d         = x2_q;
    t_d          = t_q;
    y_d          = y_q;
    acc_d        = acc_q;
    diff_d       = diff_q;
    prod_d       = prod_q;
    out_valid_d  = out_valid_q;
    sample_d     = sample_q;
    sounding_d   = sounding_q;
    ended_d      = ended_q;
    mul_a        = '0;
    mul_b        = '0;
    y_mag        = '0;
    mix_sum      = '0;
    fu_sum       = '0;
    env_nxt      = '0;

    // Configuration writes; indexes past the list are dropped
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ATTACK:  attack_d  = cfg_data_i[23:0];
        REG_DECAY:   decay_d   = cfg_data_i[23:0];
        REG_SUSTAIN: sustain_d = cfg_data_i[23:0];
        REG_RELEASE: release_d = cfg_data_i[23:0];
        REG_COEFF:   coeff_d   = cfg_data_i[15:0];
        default: ;
      endcase
    end

    // Drop the output word once taken
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (action_i)
            ACT_TICK: begin
              acc_d  = '0;
              fin_d  = 1'b0;
              part_d = 2'd0;
              if (stage_q == ENV_IDLE) begin
                // idle voice: silent word, phase and filter hold
                silent_d = 1'b1;
                state_d  = S_OUT;
              end else begin
                silent_d = 1'b0;
                state_d  = S_SX;
              end
            end
            ACT_NOTE_ON: begin
              // restart attack from the present envelope value
              phase_acc_d  = '0;
              phase_step_d = STEP_TAB[note_i];
              level_d      = LEVEL_TAB[velocity_i];
              filt_d       = '0;
              stage_d      = ENV_ATTACK;
            end
            ACT_SOFT_OFF: begin
              if (stage_q != ENV_IDLE) begin
                if (env_q != '0) begin
                  stage_d = ENV_RELEASE;
                end else begin
                  stage_d = ENV_IDLE;
                  env_d   = '0;
                end
              end
            end
            ACT_HARD_OFF: begin
              stage_d = ENV_IDLE;
              env_d   = '0;
            end
            default: ;
          endcase
        end
      end

      S_SX: begin
        mul_a   = MUL_W'(x_val);
        mul_b   = MUL_W'(x_val);
        x2_d    = mul_p[30:15];
        state_d = S_SP;
      end

      S_SP: begin
        mul_a   = MUL_W'(x2_q);
        mul_b   = MUL_W'(SINE_C2);
        t_d     = SINE_C1 - mul_p[30:15];
        state_d = S_SQ;
      end

      S_SQ: begin
        mul_a   = MUL_W'(x2_q);
        mul_b   = MUL_W'(t_q);
        t_d     = SINE_C0 - mul_p[30:15];
        state_d = S_SY;
      end

      S_SY: begin
        mul_a   = MUL_W'(x_val);
        mul_b   = MUL_W'(t_q);
        // cap at full scale, negate in the lower half wave
        y_mag   = (mul_p[30:15] > 16'd32767) ? 16'd32767 : mul_p[30:15];
        y_d     = quad[1] ? (-$signed(y_mag)) : $signed(y_mag);
        state_d = S_SW;
      end

      S_SW: begin
        mul_a = MUL_W'(y_q);
        case (part_q)
          2'd0:    mul_b = MUL_W'(MIX_W1);
          2'd1:    mul_b = MUL_W'(MIX_W2);
          default: mul_b = MUL_W'(MIX_W3);
        endcase
        acc_d = acc_q + 32'(mul_p);
        if (part_q == 2'd2) begin
          state_d = S_MIX;
        end else begin
          part_d  = part_q + 2'd1;
          state_d = S_SX;
        end
      end

      S_MIX: begin
        // round the mix to Q1.23 and take the filter difference in one add
        mix_sum = 34'(acc_q) + 34'sd128 - (34'(filt_q) <<< 8);
        diff_d  = 25'(mix_sum >>> 8);
        // advance the envelope one sample
        case (stage_q)
          ENV_ATTACK: begin
            env_nxt = $signed({2'b00, env_q}) + $signed({2'b00, attack_q});
            if (env_nxt >= $signed({2'b00, ENV_ONE})) begin
              env_d   = ENV_ONE;
              stage_d = ENV_DECAY;
            end else begin
              env_d = env_nxt[23:0];
            end
          end
          ENV_DECAY: begin
            env_nxt = $signed({2'b00, env_q}) - $signed({2'b00, decay_q});
            if (env_nxt <= $signed({2'b00, sustain_q})) begin
              env_d   = sustain_q;
              stage_d = ENV_SUSTAIN;
            end else begin
              env_d = env_nxt[23:0];
            end
          end
          ENV_SUSTAIN: begin
            env_d = sustain_q;
          end
          ENV_RELEASE: begin
            env_nxt = $signed({2'b00, env_q}) - $signed({2'b00, release_q});
            if (env_nxt <= 26'sd0) begin
              env_d   = '0;
              stage_d = ENV_IDLE;
              fin_d   = 1'b1;
            end else begin
              env_d = env_nxt[23:0];
            end
          end
          default: begin
            env_d   = '0;
            stage_d = ENV_IDLE;
          end
        endcase
        state_d = S_FM;
      end

      S_FM: begin
        mul_a   = diff_q;
        mul_b   = MUL_W'(coeff_q);
        prod_d  = 48'(mul_p);
        state_d = S_FU;
      end

      S_FU: begin
        fu_sum = 27'(filt_q) + 27'((prod_q + 48'sd32768) >>> 16);
        if (fu_sum > 27'sd8388607)       filt_d = 24'sh7FFFFF;
        else if (fu_sum < -27'sd8388608) filt_d = 24'sh800000;
        else                             filt_d = 24'(fu_sum);
        state_d = S_EM;
      end

      S_EM: begin
        mul_a   = MUL_W'(filt_q);
        mul_b   = MUL_W'(env_q);
        prod_d  = 48'(mul_p);
        state_d = S_ER;
      end

      S_ER: begin
        diff_d  = 25'(out_val);
        state_d = S_LM;
      end

      S_LM: begin
        mul_a   = diff_q;
        mul_b   = MUL_W'(level_q);
        prod_d  = 48'(mul_p);
        state_d = S_OUT;
      end

      S_OUT: begin
        // hold here while the previous word is still stalled
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if (silent_q) begin
            sample_d   = '0;
            sounding_d = 1'b0;
            ended_d    = 1'b0;
          end else begin
            if (out_val > 24'sd32767)       sample_d = 16'sh7FFF;
            else if (out_val < -24'sd32768) sample_d = 16'sh8000;
            else                            sample_d = 16'(out_val);
            sounding_d  = (stage_q != ENV_IDLE);
            ended_d     = fin_q;
            phase_acc_d = phase_acc_q + phase_step_q;
          end
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q     <= RST_ATTACK;
      decay_q      <= RST_DECAY;
      sustain_q    <= RST_SUSTAIN;
      release_q    <= RST_RELEASE;
      coeff_q      <= RST_COEFF;
      phase_acc_q  <= '0;
      phase_step_q <= '0;
      level_q      <= '0;
      filt_q       <= '0;
      env_q        <= '0;
      stage_q      <= ENV_IDLE;
      state_q      <= S_IDLE;
      part_q       <= '0;
      silent_q     <= 1'b0;
      fin_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      attack_q     <= attack_d;
      decay_q      <= decay_d;
      sustain_q    <= sustain_d;
      release_q    <= release_d;
      coeff_q      <= coeff_d;
      phase_acc_q  <= phase_acc_d;
      phase_step_q <= phase_step_d;
      level_q      <= level_d;
      filt_q       <= filt_d;
      env_q        <= env_d;
      stage_q      <= stage_d;
      state_q      <= state_d;
      part_q       <= part_d;
      silent_q     <= silent_d;
      fin_q        <= fin_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Working and payload registers, no reset
  always_ff @(posedge clk_i) begin
    x2_q       <= x2_d;
    t_q        <= t_d;
    y_q        <= y_d;
    acc_q      <= acc_d;
    diff_q     <= diff_d;
    prod_q     <= prod_d;
    sample_q   <= sample_d;
    sounding_q <= sounding_d;
    ended_q    <= ended_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign sounding_o  = sounding_q;
  assign ended_o     = ended_q;

endmodule

`default_nettype wire

/* src/asv_checker.sv */
// asv_checker: port-level assertions for the sine voice core, bound to every instance of the core.
// Depends on asv_pkg for the action codes.
`default_nettype none

module asv_checker
  import asv_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire logic [1:0]            action_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic signed [15:0]    sample_o,
  input wire logic                  sounding_o,
  input wire logic                  ended_o
);

  logic in_take;
  assign in_take = in_valid_i && !in_stall_o;

  // A stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_o)
      && $stable(sounding_o) && $stable(ended_o))
    else $error("stalled output word changed");

  // An ending voice is no longer sounding
  a_end_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ended_o |-> !sounding_o)
    else $error("ended and sounding together");

  // A word from an idle voice carries a zero sample
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sounding_o && !ended_o |-> sample_o == 16'sd0)
    else $error("idle voice gave a nonzero sample");

  // A tick occupies the voice for at least the next cycle
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && action_i == ACT_TICK |=> in_stall_o)
    else $error("tick did not occupy the voice");

  // Note and note-off words finish in the cycle they are taken
  a_ctrl_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && action_i != ACT_TICK |=> !in_stall_o)
    else $error("control word left the voice busy");

endmodule

bind additive_sine_voice_core asv_checker u_asv_checker (.*);

`default_nettype wire
